/* design/fdc_pkg.sv */
// Package for the fractional divider calculator: widths, reset value,
// payload structs and the pipeline word carried between divider stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdc_pkg;

   localparam int unsigned FREQ_BITS       = 32;
   localparam int unsigned SELECT_BITS     = 8;
   localparam int unsigned INDEX_BITS      = 2;
   localparam int unsigned INT_BITS        = 31;
   localparam int unsigned FRACTION_BITS   = 24;
   // quotient bits resolved in each divider stage
   localparam int unsigned STEPS_PER_STAGE = 2;
   localparam int unsigned QUOT_STEPS      = INT_BITS + FRACTION_BITS;
   localparam int unsigned DIV_STAGES      =
      (QUOT_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int unsigned WORK_BITS       = DIV_STAGES * STEPS_PER_STAGE;

   localparam logic [FREQ_BITS-1:0]   VCO_RESET      = 32'd2500000000;
   localparam logic [SELECT_BITS-1:0] MAX_SELECT     = 8'd3;
   localparam logic [INDEX_BITS-1:0]  OVERFLOW_INDEX = 2'd2;

   typedef logic [WORK_BITS-1:0] work_type;

   typedef struct packed {
      logic [FREQ_BITS-1:0]   out_frequency;
      logic [SELECT_BITS-1:0] out_select;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]    out_index;
      logic [INT_BITS-1:0]      integer_part;
      logic [FRACTION_BITS:0]   fraction_part;
      logic                     divide_error;
   } rsp_type;

   // work holds the unconsumed dividend bits on top and quotient bits below
   typedef struct packed {
      logic [FREQ_BITS-1:0]  divisor;
      logic [FREQ_BITS-1:0]  remainder;
      work_type              work;
      logic [INDEX_BITS-1:0] out_index;
   } div_type;

   function automatic logic [INDEX_BITS-1:0] pick_index(input logic [SELECT_BITS-1:0] sel);
      logic [INDEX_BITS-1:0] idx;
      if (sel > MAX_SELECT) begin
         idx = OVERFLOW_INDEX;
      end else begin
         idx = sel[INDEX_BITS-1:0];
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

/* design/fdc_div_stage.sv */
// One divider pipeline stage: fdc_pkg::STEPS_PER_STAGE restoring compare-and-subtract steps.
// Depends on fdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdc_div_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  wire fdc_pkg::div_type in_data,
   output logic                 out_valid,
   output fdc_pkg::div_type     out_data
);

   logic                           valid_ff;
   fdc_pkg::div_type               data_ff;
   fdc_pkg::div_type               data_in;
   logic [fdc_pkg::FREQ_BITS:0]    trial   [fdc_pkg::STEPS_PER_STAGE];
   logic [fdc_pkg::FREQ_BITS:0]    diff    [fdc_pkg::STEPS_PER_STAGE];
   logic [fdc_pkg::FREQ_BITS-1:0]  rem_s   [fdc_pkg::STEPS_PER_STAGE+1];
   fdc_pkg::work_type              work_s  [fdc_pkg::STEPS_PER_STAGE+1];

   always_comb begin
      rem_s[0]  = in_data.remainder;
      work_s[0] = in_data.work;
      for (int s = 0; s < int'(fdc_pkg::STEPS_PER_STAGE); s++) begin
         // shift in the next dividend bit and try to subtract
         trial[s] = {rem_s[s], work_s[s][fdc_pkg::WORK_BITS-1]};
         diff[s]  = trial[s] - {1'b0, in_data.divisor};
         if (!diff[s][fdc_pkg::FREQ_BITS]) begin
            rem_s[s+1]  = diff[s][fdc_pkg::FREQ_BITS-1:0];
            work_s[s+1] = {work_s[s][fdc_pkg::WORK_BITS-2:0], 1'b1};
         end else begin
            rem_s[s+1]  = trial[s][fdc_pkg::FREQ_BITS-1:0];
            work_s[s+1] = {work_s[s][fdc_pkg::WORK_BITS-2:0], 1'b0};
         end
      end
      data_in           = in_data;
      data_in.remainder = rem_s[fdc_pkg::STEPS_PER_STAGE];
      data_in.work      = work_s[fdc_pkg::STEPS_PER_STAGE];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* design/fdc_round.sv */
// Final stage: rounds the fraction half up, handles a zero divisor and
// holds the result register. Depends on fdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdc_round (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  wire fdc_pkg::div_type in_data,
   output logic                 out_valid,
   output fdc_pkg::rsp_type     out_data
);

   logic                           valid_ff;
   fdc_pkg::rsp_type               data_ff;
   fdc_pkg::rsp_type               data_in;
   logic [fdc_pkg::FREQ_BITS:0]    round_sum;
   logic                           round_up;

   always_comb begin
      // remainder plus half the divisor reaching the divisor rounds up
      round_sum = {1'b0, in_data.remainder} + {2'b00, in_data.divisor[fdc_pkg::FREQ_BITS-1:1]};
      round_up  = (round_sum >= {1'b0, in_data.divisor});
      data_in.out_index = in_data.out_index;
      if (in_data.divisor == '0) begin
         data_in.integer_part  = '0;
         data_in.fraction_part = '0;
         data_in.divide_error  = 1'b1;
      end else begin
         data_in.integer_part  = in_data.work[fdc_pkg::FRACTION_BITS +: fdc_pkg::INT_BITS];
         data_in.fraction_part = {1'b0, in_data.work[fdc_pkg::FRACTION_BITS-1:0]}
                               + {{fdc_pkg::FRACTION_BITS{1'b0}}, round_up};
         data_in.divide_error  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* design/fractional_divider_calc.sv */
// Pipeline: after the req transfer an item passes the input register,
// fdc_pkg::DIV_STAGES divider stages (28 with the default 24 fraction bits,
// resolving two quotient bits each) and the rounding stage, which drives rsp_valid.
// Throughput: one item per cycle; a stalled rsp holds the whole pipeline.
// Reset: synchronous, clears all valid bits and loads the VCO register.
`timescale 1ns / 1ps
`default_nettype none

module fractional_divider_calc (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire fdc_pkg::req_type                  req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output fdc_pkg::rsp_type                       rsp_payload,
   input  wire logic                              csr_write_enable,
   input  wire logic [fdc_pkg::FREQ_BITS-1:0]     csr_write_data
);

   logic [fdc_pkg::FREQ_BITS-1:0]  vco_ff;
   logic                           advance;
   logic [fdc_pkg::DIV_STAGES:0]   stage_valid;
   fdc_pkg::div_type               stage_data [fdc_pkg::DIV_STAGES+1];
   logic                           entry_valid_ff;
   fdc_pkg::div_type               entry_ff;
   fdc_pkg::div_type               entry_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vco_ff <= fdc_pkg::VCO_RESET;
      end else if (csr_write_enable) begin
         vco_ff <= csr_write_data;
      end
   end

   // advance whenever the result register is empty or being drained
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      entry_in.divisor   = req_payload.out_frequency;
      entry_in.remainder = '0;
      entry_in.work      = fdc_pkg::work_type'(vco_ff[fdc_pkg::FREQ_BITS-1:1])
                           << fdc_pkg::FRACTION_BITS;
      entry_in.out_index = fdc_pkg::pick_index(req_payload.out_select);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_data[0]  = entry_ff;

   for (genvar i = 0; i < int'(fdc_pkg::DIV_STAGES); i++) begin : g_div
      fdc_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   fdc_round u_round (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (stage_valid[fdc_pkg::DIV_STAGES]),
      .in_data   (stage_data[fdc_pkg::DIV_STAGES]),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload)
   );

endmodule

`default_nettype wire
